// File: src/mbe_pkg.sv
// Shared types, constants and the control store for the escape-time pixel engine.
// No dependencies; used by mbe_sequencer, mbe_datapath and mandelbrot_escape_time.
package mbe_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int COORD_W    = 32;
  localparam int CNT_W      = 16;
  localparam int HW_W       = 11;
  localparam int PIX_W      = 12;
  localparam int IDX_W      = 24;
  localparam int STEP_REG_W = 31;
  localparam int RSQ_W      = 63;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;
  localparam int OPND_W     = 32;
  localparam int PROD_W     = 64;
  localparam int WIDE_W     = 65;
  localparam int CMAG_W     = 43;
  localparam int CSUM_W     = 45;

  localparam logic signed [COORD_W-1:0] CENTER_RST = '0;
  localparam logic [STEP_REG_W-1:0]     PSTEP_RST  = 31'd268435;
  localparam logic [HW_W-1:0]           HWIDTH_RST = 11'd1000;
  localparam logic [CNT_W-1:0]          ILIMIT_RST = 16'd255;
  localparam logic [RSQ_W-1:0]          RSQ_RST    = 63'h0400_0000_0000_0000;

  localparam logic signed [WIDE_W-1:0] COORD_MAX_W = 65'sh0_0000_0000_7FFF_FFFF;
  localparam logic signed [WIDE_W-1:0] COORD_MIN_W = -65'sh0_0000_0000_8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_REAL,
    CFG_CENTER_IMAG,
    CFG_PIXEL_STEP,
    CFG_HALF_WIDTH,
    CFG_ITER_LIMIT,
    CFG_ESCAPE_RSQ
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_CR,
    MUL_CI,
    MUL_IDX,
    MUL_RR,
    MUL_II,
    MUL_RI
  } mul_sel_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_GOTO,
    JMP_COND,
    JMP_WAIT
  } jump_t;

  typedef logic [3:0] step_t;

  localparam step_t ST_MUL_CR  = 4'd0;
  localparam step_t ST_MUL_CI  = 4'd1;
  localparam step_t ST_MUL_IDX = 4'd2;
  localparam step_t ST_IDX     = 4'd3;
  localparam step_t ST_SQ_R    = 4'd4;
  localparam step_t ST_SQ_I    = 4'd5;
  localparam step_t ST_PROD    = 4'd6;
  localparam step_t ST_CHECK   = 4'd7;
  localparam step_t ST_UPDATE  = 4'd8;
  localparam step_t ST_DONE    = 4'd9;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     ld_cr;
    logic     ld_ci;
    logic     clr_z;
    logic     ld_idx;
    logic     ld_a;
    logic     ld_b;
    logic     chk;
    logic     upd;
    jump_t    jmp;
    step_t    target;
  } uword_t;

  typedef struct packed {
    logic   load;
    logic   out_ld;
    uword_t op;
  } ctrl_t;

  typedef struct packed {
    logic escape;
    logic last;
  } status_t;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    w = '0;
    w.mul_sel = MUL_NONE;
    w.jmp     = JMP_NEXT;
    w.target  = ST_MUL_CR;
    unique case (s)
      ST_MUL_CR:  w.mul_sel = MUL_CR;
      ST_MUL_CI:  begin
        w.mul_sel = MUL_CI;
        w.ld_cr   = 1'b1;
      end
      ST_MUL_IDX: begin
        w.mul_sel = MUL_IDX;
        w.ld_ci   = 1'b1;
        w.clr_z   = 1'b1;
      end
      ST_IDX:     w.ld_idx = 1'b1;
      ST_SQ_R:    w.mul_sel = MUL_RR;
      ST_SQ_I:    begin
        w.mul_sel = MUL_II;
        w.ld_a    = 1'b1;
      end
      ST_PROD:    begin
        w.mul_sel = MUL_RI;
        w.ld_b    = 1'b1;
      end
      ST_CHECK:   begin
        w.chk    = 1'b1;
        w.jmp    = JMP_COND;
        w.target = ST_DONE;
      end
      ST_UPDATE:  begin
        w.upd    = 1'b1;
        w.jmp    = JMP_GOTO;
        w.target = ST_SQ_R;
      end
      ST_DONE:    w.jmp = JMP_WAIT;
      default:    w.jmp = JMP_WAIT;
    endcase
    return w;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [WIDE_W-1:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > COORD_MAX_W) begin
      r = COORD_MAX_W[COORD_W-1:0];
    end else if (v < COORD_MIN_W) begin
      r = COORD_MIN_W[COORD_W-1:0];
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: src/mbe_sequencer.sv
// Microcode sequencer: step counter, control store lookup, jumps and the beat handshakes.
// Depends on mbe_pkg.
module mbe_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mbe_pkg::status_t status,
  output mbe_pkg::ctrl_t   ctrl
);

  logic             busy;
  logic             busy_next;
  mbe_pkg::step_t   step;
  mbe_pkg::step_t   step_next;
  logic             out_valid_next;
  mbe_pkg::uword_t  uw;
  logic             slot_free;

  assign uw        = mbe_pkg::ucode(step);
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = !busy;

  always_comb begin
    ctrl.load   = in_valid && !busy;
    ctrl.op     = busy ? uw : '0;
    ctrl.out_ld = busy && (uw.jmp == mbe_pkg::JMP_WAIT) && slot_free;
  end

  always_comb begin
    busy_next = busy;
    step_next = step;
    if (!busy) begin
      if (in_valid) begin
        busy_next = 1'b1;
        step_next = mbe_pkg::ST_MUL_CR;
      end
    end else begin
      unique case (uw.jmp)
        mbe_pkg::JMP_NEXT: step_next = step + 1'b1;
        mbe_pkg::JMP_GOTO: step_next = uw.target;
        mbe_pkg::JMP_COND: begin
          step_next = (status.escape || status.last) ? uw.target : step + 1'b1;
        end
        mbe_pkg::JMP_WAIT: begin
          if (slot_free) begin
            busy_next = 1'b0;
            step_next = mbe_pkg::ST_MUL_CR;
          end
        end
        default: step_next = mbe_pkg::ST_MUL_CR;
      endcase
    end
  end

  always_comb begin
    if (ctrl.out_ld) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= mbe_pkg::ST_MUL_CR;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// File: src/mbe_datapath.sv
// Datapath: shared 32x32 multiplier, point setup, z update, escape test and result registers.
// Depends on mbe_pkg; driven by the control word from mbe_sequencer.
module mbe_datapath (
  input  logic                                 clk,
  input  logic signed [mbe_pkg::COORD_W-1:0]   center_real,
  input  logic signed [mbe_pkg::COORD_W-1:0]   center_imag,
  input  logic [mbe_pkg::STEP_REG_W-1:0]       pixel_step,
  input  logic [mbe_pkg::HW_W-1:0]             half_width,
  input  logic [mbe_pkg::CNT_W-1:0]            iteration_limit,
  input  logic [mbe_pkg::RSQ_W-1:0]            escape_radius_sq,
  input  logic [mbe_pkg::PIX_W-1:0]            pixel_row,
  input  logic [mbe_pkg::PIX_W-1:0]            pixel_col,
  input  mbe_pkg::ctrl_t                       ctrl,
  output mbe_pkg::status_t                     status,
  output logic [mbe_pkg::CNT_W-1:0]            escape_count,
  output logic [mbe_pkg::IDX_W-1:0]            pixel_index
);

  logic [mbe_pkg::PIX_W-1:0]          row;
  logic [mbe_pkg::PIX_W-1:0]          col;
  logic [mbe_pkg::PIX_W-1:0]          r_ext;
  logic [mbe_pkg::PIX_W-1:0]          two_r;
  logic [mbe_pkg::PIX_W-1:0]          side;
  logic                               col_lt;
  logic                               row_gt;
  logic [mbe_pkg::PIX_W-1:0]          col_mag;
  logic [mbe_pkg::PIX_W-1:0]          row_mag;

  logic signed [mbe_pkg::COORD_W-1:0] cr;
  logic signed [mbe_pkg::COORD_W-1:0] ci;
  logic signed [mbe_pkg::COORD_W-1:0] zr;
  logic signed [mbe_pkg::COORD_W-1:0] zi;
  logic [mbe_pkg::OPND_W-1:0]         mr;
  logic [mbe_pkg::OPND_W-1:0]         mi;

  logic [mbe_pkg::OPND_W-1:0]         opa;
  logic [mbe_pkg::OPND_W-1:0]         opb;
  logic [mbe_pkg::PROD_W-1:0]         mul_out;
  logic [mbe_pkg::PROD_W-1:0]         prod;
  logic [mbe_pkg::PROD_W-1:0]         sq_a;
  logic [mbe_pkg::PROD_W-1:0]         sq_b;
  logic [mbe_pkg::PROD_W-1:0]         abs2;

  logic signed [mbe_pkg::CSUM_W-1:0]  cmag_s;
  logic signed [mbe_pkg::CSUM_W-1:0]  cr_sum;
  logic signed [mbe_pkg::CSUM_W-1:0]  ci_sum;

  logic signed [mbe_pkg::WIDE_W-1:0]  re_s;
  logic signed [mbe_pkg::WIDE_W-1:0]  im_s;
  logic signed [mbe_pkg::WIDE_W-1:0]  p2_s;
  logic signed [mbe_pkg::WIDE_W-1:0]  re_sh;
  logic signed [mbe_pkg::WIDE_W-1:0]  im_sh;

  logic [mbe_pkg::CNT_W-1:0]          n;
  logic [mbe_pkg::CNT_W-1:0]          count_res;
  logic [mbe_pkg::IDX_W-1:0]          idx;

  assign r_ext   = {1'b0, half_width};
  assign two_r   = {half_width, 1'b0};
  assign side    = two_r + 1'b1;
  assign col_lt  = col < r_ext;
  assign row_gt  = row > r_ext;
  assign col_mag = col_lt ? r_ext - col : col - r_ext;
  assign row_mag = row_gt ? row - r_ext : r_ext - row;

  assign mr = zr[mbe_pkg::COORD_W-1] ? -zr : zr;
  assign mi = zi[mbe_pkg::COORD_W-1] ? -zi : zi;

  always_comb begin
    case (ctrl.op.mul_sel)
      mbe_pkg::MUL_CR: begin
        opa = mbe_pkg::OPND_W'(col_mag);
        opb = mbe_pkg::OPND_W'(pixel_step);
      end
      mbe_pkg::MUL_CI: begin
        opa = mbe_pkg::OPND_W'(row_mag);
        opb = mbe_pkg::OPND_W'(pixel_step);
      end
      mbe_pkg::MUL_IDX: begin
        opa = mbe_pkg::OPND_W'(row);
        opb = mbe_pkg::OPND_W'(side);
      end
      mbe_pkg::MUL_RR: begin
        opa = mr;
        opb = mr;
      end
      mbe_pkg::MUL_II: begin
        opa = mi;
        opb = mi;
      end
      mbe_pkg::MUL_RI: begin
        opa = mr;
        opb = mi;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign mul_out = opa * opb;

  // pixel offset magnitude lives in prod; sign comes from the clamped row/col
  assign cmag_s = $signed({2'b00, prod[mbe_pkg::CMAG_W-1:0]});
  assign cr_sum = mbe_pkg::CSUM_W'(center_real) + (col_lt ? -cmag_s : cmag_s);
  assign ci_sum = mbe_pkg::CSUM_W'(center_imag) + (row_gt ? -cmag_s : cmag_s);

  assign abs2  = sq_a + sq_b;
  assign p2_s  = $signed({prod, 1'b0});
  assign re_sh = re_s >>> mbe_pkg::FRAC_BITS;
  assign im_sh = im_s >>> mbe_pkg::FRAC_BITS;

  always_comb begin
    status.escape = abs2 >= {1'b0, escape_radius_sq};
    status.last   = n == iteration_limit;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      row <= (pixel_row > two_r) ? two_r : pixel_row;
      col <= (pixel_col > two_r) ? two_r : pixel_col;
    end
    if (ctrl.op.mul_sel != mbe_pkg::MUL_NONE) begin
      prod <= mul_out;
    end
    if (ctrl.op.ld_cr) begin
      cr <= mbe_pkg::sat_coord(mbe_pkg::WIDE_W'(cr_sum));
    end
    if (ctrl.op.ld_ci) begin
      ci <= mbe_pkg::sat_coord(mbe_pkg::WIDE_W'(ci_sum));
    end
    if (ctrl.op.ld_idx) begin
      idx <= prod[mbe_pkg::IDX_W-1:0] + mbe_pkg::IDX_W'(col);
    end
    if (ctrl.op.ld_a) begin
      sq_a <= prod;
    end
    if (ctrl.op.ld_b) begin
      sq_b <= prod;
    end
    if (ctrl.op.chk) begin
      re_s      <= $signed({1'b0, sq_a}) - $signed({1'b0, sq_b});
      im_s      <= (zr[mbe_pkg::COORD_W-1] != zi[mbe_pkg::COORD_W-1]) ? -p2_s : p2_s;
      count_res <= status.escape ? n : '0;
    end
    if (ctrl.op.clr_z) begin
      zr <= '0;
      zi <= '0;
      n  <= '0;
    end else if (ctrl.op.upd) begin
      zr <= mbe_pkg::sat_coord(re_sh + mbe_pkg::WIDE_W'(cr));
      zi <= mbe_pkg::sat_coord(im_sh + mbe_pkg::WIDE_W'(ci));
      n  <= n + 1'b1;
    end
    if (ctrl.out_ld) begin
      escape_count <= count_res;
      pixel_index  <= idx;
    end
  end

endmodule

// File: src/mandelbrot_escape_time.sv
// Top level of the escape-time pixel engine: configuration registers, sequencer, datapath.
// Depends on mbe_pkg, mbe_sequencer and mbe_datapath.
//
// One pixel (row, column) is taken per input beat and one beat comes out per pixel:
// the escape count and the pixel's linear index. All work goes through a single
// 32x32 multiplier under a ten-step microprogram: the setup steps MUL_CR, MUL_CI,
// MUL_IDX and IDX form c and the index, then each escape check runs SQ_R, SQ_I,
// PROD and CHECK (two squares, the cross product and the test), and each check
// that neither escapes nor reaches the iteration limit adds an UPDATE step. The
// next pixel is accepted as soon as the previous result has moved into the output
// register. Configuration must be written by the user only while no pixel is in
// flight; the block itself does not enforce this.
module mandelbrot_escape_time (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbe_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [mbe_pkg::PIX_W-1:0]          pixel_row,
  input  logic [mbe_pkg::PIX_W-1:0]          pixel_col,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mbe_pkg::CNT_W-1:0]          escape_count,
  output logic [mbe_pkg::IDX_W-1:0]          pixel_index
);

  logic signed [mbe_pkg::COORD_W-1:0] center_real;
  logic signed [mbe_pkg::COORD_W-1:0] center_imag;
  logic [mbe_pkg::STEP_REG_W-1:0]     pixel_step;
  logic [mbe_pkg::HW_W-1:0]           half_width;
  logic [mbe_pkg::CNT_W-1:0]          iteration_limit;
  logic [mbe_pkg::RSQ_W-1:0]          escape_radius_sq;

  mbe_pkg::ctrl_t   ctrl;
  mbe_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_real      <= mbe_pkg::CENTER_RST;
      center_imag      <= mbe_pkg::CENTER_RST;
      pixel_step       <= mbe_pkg::PSTEP_RST;
      half_width       <= mbe_pkg::HWIDTH_RST;
      iteration_limit  <= mbe_pkg::ILIMIT_RST;
      escape_radius_sq <= mbe_pkg::RSQ_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbe_pkg::CFG_CENTER_REAL: center_real      <= $signed(cfg_data[mbe_pkg::COORD_W-1:0]);
        mbe_pkg::CFG_CENTER_IMAG: center_imag      <= $signed(cfg_data[mbe_pkg::COORD_W-1:0]);
        mbe_pkg::CFG_PIXEL_STEP:  pixel_step       <= cfg_data[mbe_pkg::STEP_REG_W-1:0];
        mbe_pkg::CFG_HALF_WIDTH:  half_width       <= cfg_data[mbe_pkg::HW_W-1:0];
        mbe_pkg::CFG_ITER_LIMIT:  iteration_limit  <= cfg_data[mbe_pkg::CNT_W-1:0];
        mbe_pkg::CFG_ESCAPE_RSQ:  escape_radius_sq <= cfg_data[mbe_pkg::RSQ_W-1:0];
        default: ;
      endcase
    end
  end

  mbe_sequencer u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  mbe_datapath u_dp (
    .clk              (clk),
    .center_real      (center_real),
    .center_imag      (center_imag),
    .pixel_step       (pixel_step),
    .half_width       (half_width),
    .iteration_limit  (iteration_limit),
    .escape_radius_sq (escape_radius_sq),
    .pixel_row        (pixel_row),
    .pixel_col        (pixel_col),
    .ctrl             (ctrl),
    .status           (status),
    .escape_count     (escape_count),
    .pixel_index      (pixel_index)
  );

  // busy right after an input beat
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("engine accepted a beat but did not go busy");

  // a result never appears the cycle after its pixel was taken
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result produced without running the program");

  // linear index stays on the largest grid
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_index <= 24'd16769024))
    else $error("pixel index outside the grid");

  // escape checks and z updates only happen while the program is running
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.op.upd || ctrl.op.chk) |-> !in_ready)
    else $error("datapath step issued while idle");

endmodule

// File: bench/tb.sv
// Self-checking bench for mandelbrot_escape_time: drives pixels and register writes,
// predicts each escape count and pixel index in Q4.28 fixed point, and checks every beat.
// Depends on mbe_pkg and the mandelbrot_escape_time RTL.
`timescale 1ns / 100ps

module tb;

  localparam logic [mbe_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [mbe_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam longint COORD_HI = 64'sd2147483647;
  localparam longint COORD_LO = -64'sd2147483648;
  localparam logic [31:0] Q_ONE = 32'h1000_0000;

  typedef struct packed {
    logic [mbe_pkg::CNT_W-1:0] count;
    logic [mbe_pkg::IDX_W-1:0] index;
  } pixel_result_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [mbe_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [mbe_pkg::PIX_W-1:0]      pixel_row = '0;
  logic [mbe_pkg::PIX_W-1:0]      pixel_col = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [mbe_pkg::CNT_W-1:0]      escape_count;
  logic [mbe_pkg::IDX_W-1:0]      pixel_index;

  // shadow copy of the register file
  logic [mbe_pkg::COORD_W-1:0]    center_re_q = mbe_pkg::CENTER_RST;
  logic [mbe_pkg::COORD_W-1:0]    center_im_q = mbe_pkg::CENTER_RST;
  logic [mbe_pkg::STEP_REG_W-1:0] step_q = mbe_pkg::PSTEP_RST;
  logic [mbe_pkg::HW_W-1:0]       half_q = mbe_pkg::HWIDTH_RST;
  logic [mbe_pkg::CNT_W-1:0]      limit_q = mbe_pkg::ILIMIT_RST;
  logic [mbe_pkg::RSQ_W-1:0]      rsq_q = mbe_pkg::RSQ_RST;

  pixel_result_t pending_results[$];
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_left = 0;

  mandelbrot_escape_time uut (.*);

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic longint clip_coord(input longint v);
    if (v > COORD_HI) return COORD_HI;
    if (v < COORD_LO) return COORD_LO;
    return v;
  endfunction

  // floor of +-m / 2^28
  function automatic longint floor_q28(input bit [63:0] m, input bit neg);
    bit [63:0] up;
    up = (m + 64'h0FFF_FFFF) >> mbe_pkg::FRAC_BITS;
    return neg ? -longint'(up) : longint'(m >> mbe_pkg::FRAC_BITS);
  endfunction

  function automatic pixel_result_t escape_time_of(input logic [mbe_pkg::PIX_W-1:0] row_in,
                                                   input logic [mbe_pkg::PIX_W-1:0] col_in);
    pixel_result_t res;
    longint r, row, col, cr, ci, zr, zi, pos;
    bit [63:0] mr, mi, sq_r, sq_i, mag_sq, re_m, im_m;
    bit [64:0] sum;
    bit re_neg, im_neg;
    int unsigned iters;
    r = longint'(half_q);
    row = longint'(row_in);
    col = longint'(col_in);
    if (row > 2 * r) row = 2 * r;
    if (col > 2 * r) col = 2 * r;
    cr = clip_coord(longint'(signed'(center_re_q)) + longint'(step_q) * (col - r));
    ci = clip_coord(longint'(signed'(center_im_q)) + longint'(step_q) * (r - row));
    zr = 0;
    zi = 0;
    iters = 0;
    for (int unsigned n = 0; n <= limit_q; n++) begin
      mr = (zr < 0) ? -zr : zr;
      mi = (zi < 0) ? -zi : zi;
      sq_r = (mr > 64'hFFFF_FFFF) ? '1 : mr * mr;
      sq_i = (mi > 64'hFFFF_FFFF) ? '1 : mi * mi;
      sum = {1'b0, sq_r} + {1'b0, sq_i};
      mag_sq = sum[64] ? '1 : sum[63:0];
      if (mag_sq >= rsq_q) begin
        iters = n;
        break;
      end
      if (sq_r >= sq_i) begin
        re_m = sq_r - sq_i;
        re_neg = 1'b0;
      end else begin
        re_m = sq_i - sq_r;
        re_neg = 1'b1;
      end
      im_m = (mr * mi) << 1;
      im_neg = ((zr < 0) != (zi < 0)) && (im_m != 0);
      zr = clip_coord(floor_q28(re_m, re_neg) + cr);
      zi = clip_coord(floor_q28(im_m, im_neg) + ci);
    end
    pos = row * (2 * r + 1) + col;
    res.count = iters[mbe_pkg::CNT_W-1:0];
    res.index = pos[mbe_pkg::IDX_W-1:0];
    return res;
  endfunction

  // result checker
  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected beat: escape_count %0d pixel_index %0d", escape_count, pixel_index);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (escape_count !== want.count) begin
          $error("escape_count expected %0d got %0d", want.count, escape_count);
          err_count++;
        end
        if (pixel_index !== want.index) begin
          $error("pixel_index expected %0d got %0d", want.index, pixel_index);
          err_count++;
        end
      end
    end
  end

  // receiver: random stalls, or a counted hold-off
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ready = 1'b0;
      hold_off_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // all tasks start and end on a falling edge
  task automatic send_pixel(input logic [mbe_pkg::PIX_W-1:0] row,
                            input logic [mbe_pkg::PIX_W-1:0] col);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    pixel_row = row;
    pixel_col = col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(escape_time_of(row, col));
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [mbe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mbe_pkg::CFG_DATA_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      mbe_pkg::CFG_CENTER_REAL: center_re_q = data[mbe_pkg::COORD_W-1:0];
      mbe_pkg::CFG_CENTER_IMAG: center_im_q = data[mbe_pkg::COORD_W-1:0];
      mbe_pkg::CFG_PIXEL_STEP:  step_q = data[mbe_pkg::STEP_REG_W-1:0];
      mbe_pkg::CFG_HALF_WIDTH:  half_q = data[mbe_pkg::HW_W-1:0];
      mbe_pkg::CFG_ITER_LIMIT:  limit_q = data[mbe_pkg::CNT_W-1:0];
      mbe_pkg::CFG_ESCAPE_RSQ:  rsq_q = data[mbe_pkg::RSQ_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // sometimes fill the bits above the register width with noise
  function automatic logic [mbe_pkg::CFG_DATA_W-1:0] pad_junk(
      input logic [mbe_pkg::CFG_DATA_W-1:0] v, input int w);
    logic [mbe_pkg::CFG_DATA_W-1:0] keep;
    keep = (63'd1 << w) - 63'd1;
    if ($urandom_range(1) == 0) return v;
    return (v & keep) | (mbe_pkg::CFG_DATA_W'({$urandom, $urandom}) & ~keep);
  endfunction

  task automatic configure(input logic [31:0] cre, input logic [31:0] cim,
                           input logic [30:0] stp, input logic [10:0] hw,
                           input logic [15:0] lim, input logic [62:0] rsq);
    wait_for_results();
    write_reg(mbe_pkg::CFG_CENTER_REAL, pad_junk(63'(cre), mbe_pkg::COORD_W));
    write_reg(mbe_pkg::CFG_CENTER_IMAG, pad_junk(63'(cim), mbe_pkg::COORD_W));
    write_reg(mbe_pkg::CFG_PIXEL_STEP, pad_junk(63'(stp), mbe_pkg::STEP_REG_W));
    write_reg(mbe_pkg::CFG_HALF_WIDTH, pad_junk(63'(hw), mbe_pkg::HW_W));
    write_reg(mbe_pkg::CFG_ITER_LIMIT, pad_junk(63'(lim), mbe_pkg::CNT_W));
    write_reg(mbe_pkg::CFG_ESCAPE_RSQ, rsq);
  endtask

  task automatic random_config();
    logic [31:0] cre, cim;
    logic [30:0] stp;
    logic [10:0] hw;
    logic [15:0] lim;
    logic [62:0] rsq;
    int pick;
    cre = $urandom;
    cim = $urandom;
    if ($urandom_range(3) != 0) begin
      cre = {{2{cre[29]}}, cre[29:0]};
      cim = {{2{cim[29]}}, cim[29:0]};
    end
    pick = $urandom_range(99);
    if (pick < 10) stp = '0;
    else if (pick < 25) stp = 31'($urandom);
    else stp = 31'($urandom_range(1, 32'h0400_0000));
    pick = $urandom_range(99);
    if (pick < 5) hw = '0;
    else if (pick < 10) hw = '1;
    else if (pick < 30) hw = 11'($urandom_range(0, 2047));
    else hw = 11'($urandom_range(1, 16));
    if ($urandom_range(99) < 80) lim = 16'($urandom_range(0, 20));
    else lim = 16'($urandom_range(21, 120));
    pick = $urandom_range(99);
    if (pick < 70) rsq = mbe_pkg::RSQ_RST;
    else if (pick < 90) rsq = 63'({$urandom, $urandom} >> 2);
    else rsq = 63'({$urandom, $urandom});
    configure(cre, cim, stp, hw, lim, rsq);
  endtask

  function automatic logic [mbe_pkg::PIX_W-1:0] pick_coord();
    if ($urandom_range(99) < 85) begin
      return mbe_pkg::PIX_W'($urandom_range(0, 2 * int'(half_q)));
    end
    return mbe_pkg::PIX_W'($urandom_range(0, 4095));
  endfunction

  task automatic test_reset_defaults();
    send_pixel(12'd1000, 12'd1000);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd2000);
  endtask

  task automatic test_grid_extremes();
    // one-pixel grid: everything clamps to the center
    configure(32'hF400_0000, 32'h0199_999A, 31'h1000_0000, 11'd0, 16'd40, mbe_pkg::RSQ_RST);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd9, 12'd0);
    // widest grid, largest step: c saturates at the edges
    configure(32'h0, 32'h0, 31'h7FFF_FFFF, 11'd2047, 16'd20, mbe_pkg::RSQ_RST);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd0, 12'd4094);
    send_pixel(12'd4094, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2047, 12'd2047);
    // zero step
    configure(32'hF800_0000, 32'h0, 31'd0, 11'd5, 16'd30, mbe_pkg::RSQ_RST);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd10, 12'd7);
  endtask

  task automatic test_threshold_extremes();
    configure(Q_ONE, 32'h0, mbe_pkg::PSTEP_RST, mbe_pkg::HWIDTH_RST, mbe_pkg::ILIMIT_RST,
              63'd0);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1000, 12'd1000);
    // |z|^2 right around the largest threshold
    configure(32'h8000_0000, 32'h8000_0000, 31'd0, 11'd0, 16'd10, '1);
    send_pixel(12'd0, 12'd0);
    configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0, 11'd0, 16'd10, '1);
    send_pixel(12'd3, 12'd3);
  endtask

  task automatic test_iteration_limits();
    configure(32'h0800_0000, 32'h0, 31'h0010_0000, 11'd4, 16'd0, mbe_pkg::RSQ_RST);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd8, 12'd8);
    // full limit, but these points leave at once
    configure(32'h7FFF_FFFF, 32'h0, 31'd0, 11'd0, 16'hFFFF, mbe_pkg::RSQ_RST);
    send_pixel(12'd0, 12'd0);
    configure(32'h8000_0000, 32'h0, 31'd0, 11'd0, 16'hFFFF, mbe_pkg::RSQ_RST);
    send_pixel(12'd5, 12'd5);
  endtask

  task automatic test_spare_indexes();
    configure(32'hF800_0000, 32'h0, 31'h0100_0000, 11'd6, 16'd25, mbe_pkg::RSQ_RST);
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, 63'h5A5A_A5A5_5A5A_A5A5);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd6, 12'd6);
    send_pixel(12'd12, 12'd3);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure(32'h0, 32'h0, 31'h0200_0000, 11'd8, 16'd6, mbe_pkg::RSQ_RST);
    hold_off_left = 300;
    repeat (16) begin
      send_pixel(mbe_pkg::PIX_W'($urandom_range(16)), mbe_pkg::PIX_W'($urandom_range(16)));
    end
    wait_for_results();
  endtask

  task automatic test_random_mix(input int n_items, input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 40 == 0) random_config();
      send_pixel(pick_coord(), pick_coord());
    end
    wait_for_results();
  endtask

  initial begin
    int tail;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_grid_extremes();
    test_threshold_extremes();
    test_iteration_limits();
    test_spare_indexes();
    test_backpressure();
    test_random_mix(200, 0, 0);
    test_random_mix(200, 78, 0);
    test_random_mix(200, 0, 78);
    test_random_mix(200, 19, 19);
    tail = 5 * int'(limit_q) + 20;
    if (tail > 2000) tail = 2000;
    repeat (tail) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
